### design/plc_pkg.sv
package plc_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int POS_W           = 7;
  localparam int DATA_W          = 32;
  localparam int GROUP_SIZE      = 8;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOCATE = 2'd2;
  localparam logic [1:0] OP_DUMP   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADPOS   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t        cmd;
    logic [POS_W-1:0] idx;
    logic [POS_W-1:0] last_idx;
    logic [POS_W-1:0] count;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOCATE,
    S_DELETE,
    S_DUMP
  } state_t;

endpackage

### design/plc_cell.sv
module plc_cell import plc_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int INDEX       = 0
) (
  input  logic                          clk,
  input  cell_ctl_t                     ctl,
  input  logic signed [VALUE_WIDTH-1:0] key,
  input  logic signed [VALUE_WIDTH-1:0] left,
  input  logic signed [VALUE_WIDTH-1:0] right,
  input  logic signed [VALUE_WIDTH-1:0] head,
  output logic signed [VALUE_WIDTH-1:0] word,
  output logic signed [VALUE_WIDTH-1:0] sel_word,
  output logic                          match
);

  localparam logic [POS_W-1:0] SLOT = POS_W'(INDEX);

  logic signed [VALUE_WIDTH-1:0] word_next;

  always_comb begin
    word_next = word;
    case (ctl.cmd)
      CELL_INSERT: begin
        if (SLOT > ctl.idx) begin
          word_next = left;
        end else if (SLOT == ctl.idx) begin
          word_next = key;
        end
      end
      CELL_DELETE: begin
        if (SLOT >= ctl.idx) begin
          word_next = right;
        end
      end
      CELL_ROTATE: begin
        if (SLOT == ctl.last_idx) begin
          word_next = head;
        end else if (SLOT < ctl.last_idx) begin
          word_next = right;
        end
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  assign sel_word = (SLOT == ctl.idx) ? word : '0;
  assign match    = (word == key) && (SLOT < ctl.count);

endmodule

### design/positional_list_store.sv
// channel   direction  handshake                      payload
// request   in         start high while busy low      operation, position, value
// result    out        done high for one cycle        status, value_res, position_res,
//                                                     count, last
//
// insert and rejected requests: result in the cycle after the transfer, busy stays low
// locate and delete: busy in S_LOCATE or S_DELETE while the cell chain is read out
// dump: one result per cycle, count results in all, as the chain rotates through cell 0
// reset clears the fill count and the sequencer; cell contents are not cleared
// results cannot be held off; each is valid only in its done cycle
module positional_list_store import plc_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               operation,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] value,
  output logic                     done,
  output logic [2:0]               status,
  output logic signed [DATA_W-1:0] value_res,
  output logic [POS_W-1:0]         position_res,
  output logic [POS_W-1:0]         count,
  output logic                     last
);

  localparam int GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam logic [POS_W-1:0] CAP = POS_W'(CAPACITY);

  state_t state, state_next;
  logic [POS_W-1:0] fill_count, fill_count_next;
  logic [POS_W-1:0] dump_pos, dump_pos_next;

  cell_ctl_t ctl;
  logic signed [VALUE_WIDTH-1:0] key;
  logic signed [VALUE_WIDTH-1:0] words [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] sel_pad [GROUPS*GROUP_SIZE];
  logic signed [VALUE_WIDTH-1:0] grp_or [GROUPS];
  logic signed [VALUE_WIDTH-1:0] grp_q [GROUPS];
  logic signed [VALUE_WIDTH-1:0] picked;
  logic [CAPACITY-1:0] match, match_q;

  logic accept, ins_bad, del_bad, is_full, dump_end;
  logic found;
  logic [POS_W-1:0] found_pos;

  logic                     done_next, last_next;
  logic [2:0]               status_next;
  logic signed [DATA_W-1:0] value_res_next;
  logic [POS_W-1:0]         position_res_next;

  assign key    = VALUE_WIDTH'(value);
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign ins_bad  = (position == '0) ||
                    ({1'b0, position} > ({1'b0, fill_count} + (POS_W+1)'(1)));
  assign del_bad  = (position == '0) || (position > fill_count);
  assign is_full  = (fill_count >= CAP);
  assign dump_end = (dump_pos == (fill_count - POS_W'(1)));

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = words[0];
    end else begin : g_mid
      assign left_w = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_w = words[CAPACITY-1];
    end else begin : g_inner
      assign right_w = words[i+1];
    end
    plc_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .INDEX       (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .key      (key),
      .left     (left_w),
      .right    (right_w),
      .head     (words[0]),
      .word     (words[i]),
      .sel_word (sel_pad[i]),
      .match    (match[i])
    );
  end

  for (genvar i = CAPACITY; i < GROUPS*GROUP_SIZE; i++) begin : g_pad
    assign sel_pad[i] = '0;
  end

  // first stage of the delete readout tree
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_or[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        grp_or[g] = grp_or[g] | sel_pad[g*GROUP_SIZE + j];
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_q   <= grp_or;
    match_q <= match;
  end

  always_comb begin
    picked = '0;
    for (int g = 0; g < GROUPS; g++) begin
      picked = picked | grp_q[g];
    end
  end

  always_comb begin
    found     = 1'b0;
    found_pos = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        found     = 1'b1;
        found_pos = POS_W'(i + 1);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (operation)
            OP_DELETE: begin
              if (fill_count != '0 && !del_bad) begin
                state_next = S_DELETE;
              end
            end
            OP_LOCATE: begin
              state_next = S_LOCATE;
            end
            OP_DUMP: begin
              if (fill_count != '0) begin
                state_next = S_DUMP;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_LOCATE: state_next = S_IDLE;
      S_DELETE: state_next = S_IDLE;
      S_DUMP: begin
        if (dump_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and cell control
  always_comb begin
    ctl.cmd           = CELL_HOLD;
    ctl.idx           = position - POS_W'(1);
    ctl.last_idx      = fill_count - POS_W'(1);
    ctl.count         = fill_count;
    fill_count_next   = fill_count;
    dump_pos_next     = dump_pos;
    done_next         = 1'b0;
    status_next       = ST_OK;
    value_res_next    = '0;
    position_res_next = '0;
    last_next         = 1'b1;
    case (state)
      S_IDLE: begin
        dump_pos_next = '0;
        if (accept) begin
          case (operation)
            OP_INSERT: begin
              done_next = 1'b1;
              if (ins_bad) begin
                status_next = ST_BADPOS;
              end else if (is_full) begin
                status_next = ST_FULL;
              end else begin
                ctl.cmd         = CELL_INSERT;
                fill_count_next = fill_count + POS_W'(1);
              end
            end
            OP_DELETE: begin
              if (fill_count == '0) begin
                done_next   = 1'b1;
                status_next = ST_EMPTY;
              end else if (del_bad) begin
                done_next   = 1'b1;
                status_next = ST_BADPOS;
              end else begin
                ctl.cmd         = CELL_DELETE;
                fill_count_next = fill_count - POS_W'(1);
              end
            end
            OP_DUMP: begin
              if (fill_count == '0) begin
                done_next   = 1'b1;
                status_next = ST_EMPTY;
              end
            end
            default: begin
              done_next = 1'b0;
            end
          endcase
        end
      end
      S_LOCATE: begin
        done_next         = 1'b1;
        status_next       = found ? ST_OK : ST_NOTFOUND;
        position_res_next = found_pos;
      end
      S_DELETE: begin
        done_next      = 1'b1;
        value_res_next = DATA_W'(picked);
      end
      S_DUMP: begin
        ctl.cmd           = CELL_ROTATE;
        done_next         = 1'b1;
        value_res_next    = DATA_W'(words[0]);
        position_res_next = dump_pos + POS_W'(1);
        last_next         = dump_end;
        dump_pos_next     = dump_pos + POS_W'(1);
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      dump_pos   <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      dump_pos   <= dump_pos_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    status       <= status_next;
    value_res    <= value_res_next;
    position_res <= position_res_next;
    count        <= fill_count_next;
    last         <= last_next;
  end

endmodule

### design/plc_checker.sv
module plc_checker import plc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic [2:0]       status,
  input logic             last
);

  // every transfer gives a result next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("transfer neither answered nor in progress");

  // dump results come back to back
  a_stream_gapless: assert property (@(posedge clk) disable iff (rst)
    (done && !last) |=> done)
    else $error("gap inside a result stream");

  a_stream_busy: assert property (@(posedge clk) disable iff (rst)
    (done && !last) |-> busy)
    else $error("idle before final result");

  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    (done && last) |-> !busy)
    else $error("busy after final result");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> last)
    else $error("error status on a non-final result");

endmodule

bind positional_list_store plc_checker u_plc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .status (status),
  .last   (last)
);
